// ===== rtl/core/swgs_pkg.sv =====
// Package for the shallow water grid block: widths, codes and reset values.
// No dependencies.
package swgs_pkg;
    localparam int GridSide = 256;
    localparam int CoordW = 8;
    localparam int AddrW = 16;
    localparam int ValW = 18;
    localparam int FracBits = 12;
    localparam int GainW = 16;
    localparam logic signed [ValW-1:0] ValMax = 18'sd131071;
    localparam logic signed [ValW-1:0] ValMin = -18'sd131072;
    localparam logic signed [ValW-1:0] HeightReset = 18'sd4096;
    localparam logic [GainW-1:0] VelGainReset = 16'd5022;
    localparam logic [GainW-1:0] HeightGainReset = 16'd512;
    localparam logic [CoordW-1:0] LastCoord = 8'(GridSide - 1);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic CFG_VEL_GAIN = 1'b0;
    localparam logic CFG_HEIGHT_GAIN = 1'b1;
endpackage

// ===== rtl/core/shallow_water_grid_step.sv =====
// Shallow water grid engine: three cell memories, one shared multiply unit
// and a sequencer. Depends on swgs_pkg.
//
// Usage: s_axis carries one command per transaction (write, step or read a
// cell); m_axis returns exactly one result per command. cfg carries writes
// of vel_gain (index 0) and height_gain (index 1).
// After reset the block runs a clearing pass, one cell per
// cycle, setting every height to 1.0 and every velocity to zero; commands
// are not accepted meanwhile. Configuration writes are always taken.
// A write or unused command goes from acceptance straight to the output
// state, and a read first passes the read and read-wait states; the next
// command is taken once the block is back in idle. A step command makes a
// velocity pass and then a height pass over the interior cells. Per cell the
// velocity pass fetches five reads through the single read port, then does
// two multiply and write-back pairs and one advance, and the height pass
// fetches likewise, then does one multiply, one write back and one advance.
// The result stays in the output register until m_axis_tready is high.
// One further command may be accepted meanwhile; it waits before its own
// result until the register is free, and the block takes no more commands.
module shallow_water_grid_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: cmd[1:0], cell_x[9:2], cell_y[17:10], new_height[35:18],
    // new_vel_x[53:36], new_vel_y[71:54]
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: height_out[17:0], vel_x_out[35:18], vel_y_out[53:36],
    // saturated[54], zeros above
    output logic [55:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int VW = swgs_pkg::ValW;
    localparam int AW = swgs_pkg::AddrW;
    localparam int CW = swgs_pkg::CoordW;
    localparam int GainW_C = swgs_pkg::GainW + 3;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_RD    = 9'b000000100,
        S_RDW   = 9'b000001000,
        S_FETCH = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_UPD   = 9'b001000000,
        S_NEXT  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [VW-1:0] mem_h [2**AW];
    logic [VW-1:0] mem_vx [2**AW];
    logic [VW-1:0] mem_vy [2**AW];

    logic [15:0] r_vel_gain, r_height_gain;
    logic [AW-1:0] r_clr;
    logic [CW-1:0] r_col, r_row;
    logic r_phase;
    logic [2:0] r_sub;  // fetch slot: 0 center, 1..4 neighbors, 5 second axis
    logic r_sat;
    logic [1:0] r_cmd;
    logic [CW-1:0] r_cx, r_cy;
    logic [VW-1:0] r_rd_h, r_rd_vx, r_rd_vy;
    logic signed [VW-1:0] r_ch, r_cvx, r_cvy;
    logic signed [VW:0] r_d1, r_d2;
    logic signed [VW+1:0] r_acc;
    logic signed [VW+GainW_C-1:0] r_prod;
    logic r_axis;  // 0 x-axis, 1 y-axis in velocity pass
    logic [55:0] r_out;
    logic r_ovalid;

    logic [AW-1:0] rd_addr;
    logic [VW-1:0] r_q_h, r_q_vx, r_q_vy;

    assign o_cfg_ready = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_gain <= swgs_pkg::VelGainReset;
            r_height_gain <= swgs_pkg::HeightGainReset;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == swgs_pkg::CFG_VEL_GAIN) r_vel_gain <= i_cfg_data;
            else r_height_gain <= i_cfg_data;
        end
    end

    // Neighbor address for the current fetch slot, or the command's cell in a read.
    always_comb begin
        rd_addr = {r_row, r_col};
        case (r_sub)
            3'd1: rd_addr = {r_row, r_col + 8'd1};
            3'd2: rd_addr = {r_row, r_col - 8'd1};
            3'd3: rd_addr = {r_row + 8'd1, r_col};
            3'd4: rd_addr = {r_row - 8'd1, r_col};
            default: rd_addr = {r_row, r_col};
        endcase
        if (r_state == S_RD) rd_addr = {r_cy, r_cx};
    end

    always_ff @(posedge i_clk) begin
        r_q_h <= mem_h[rd_addr];
        r_q_vx <= mem_vx[rd_addr];
        r_q_vy <= mem_vy[rd_addr];
    end

    // Rounded product and saturated update, built from registered values.
    logic signed [VW+GainW_C-1:0] rnd;
    logic signed [VW+GainW_C-1:0] delta;
    logic signed [VW+GainW_C:0] upd;
    logic signed [VW-1:0] oldv, newv;
    logic upd_sat;
    always_comb begin
        rnd = r_prod + (VW+GainW_C)'(1 << (swgs_pkg::FracBits - 1));
        delta = rnd >>> swgs_pkg::FracBits;
        oldv = r_phase ? r_ch : (r_axis ? r_cvy : r_cvx);
        upd = (VW+GainW_C+1)'(oldv) - (VW+GainW_C+1)'(delta);
        upd_sat = 1'b0;
        newv = upd[VW-1:0];
        if (upd > (VW+GainW_C+1)'(swgs_pkg::ValMax)) begin
            newv = swgs_pkg::ValMax; upd_sat = 1'b1;
        end else if (upd < (VW+GainW_C+1)'(swgs_pkg::ValMin)) begin
            newv = swgs_pkg::ValMin; upd_sat = 1'b1;
        end
    end

    logic [AW-1:0] ctr;
    assign ctr = {r_row, r_col};

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            mem_h[r_clr] <= swgs_pkg::HeightReset;
            mem_vx[r_clr] <= '0;
            mem_vy[r_clr] <= '0;
        end else if (r_state == S_IDLE && s_axis_tvalid
                     && s_axis_tdata[1:0] == swgs_pkg::CMD_WRITE) begin
            mem_h[s_axis_tdata[17:2]] <= s_axis_tdata[35:18];
            mem_vx[s_axis_tdata[17:2]] <= s_axis_tdata[53:36];
            mem_vy[s_axis_tdata[17:2]] <= s_axis_tdata[71:54];
        end else if (r_state == S_UPD) begin
            if (r_phase) mem_h[ctr] <= newv;
            else if (r_axis) mem_vy[ctr] <= newv;
            else mem_vx[ctr] <= newv;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == '1) n_state = S_IDLE;
            S_IDLE: if (s_axis_tvalid) begin
                case (s_axis_tdata[1:0])
                    swgs_pkg::CMD_STEP: n_state = S_FETCH;
                    swgs_pkg::CMD_READ: n_state = S_RD;
                    default: n_state = S_OUT;
                endcase
            end
            S_RD: n_state = S_RDW;
            S_RDW: n_state = S_OUT;
            S_FETCH: if (r_sub == 3'd6) n_state = S_MUL;
            S_MUL: n_state = S_UPD;
            S_UPD: n_state = (!r_phase && !r_axis) ? S_MUL : S_NEXT;
            S_NEXT: n_state = (r_phase && r_row == swgs_pkg::LastCoord - 8'd1
                               && r_col == swgs_pkg::LastCoord - 8'd1) ? S_OUT : S_FETCH;
            S_OUT: if (!r_ovalid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
            r_sub <= '0;
            r_phase <= 1'b0;
            r_axis <= 1'b0;
            r_sat <= 1'b0;
            r_col <= 8'd1;
            r_row <= 8'd1;
        end else begin
            r_state <= n_state;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    r_cmd <= s_axis_tdata[1:0];
                    r_cx <= s_axis_tdata[9:2];
                    r_cy <= s_axis_tdata[17:10];
                    r_sub <= '0; r_phase <= 1'b0; r_axis <= 1'b0; r_sat <= 1'b0;
                    r_col <= 8'd1; r_row <= 8'd1;
                    r_rd_h <= '0; r_rd_vx <= '0; r_rd_vy <= '0;
                end
                S_RDW: begin
                    r_rd_h <= r_q_h; r_rd_vx <= r_q_vx; r_rd_vy <= r_q_vy;
                end
                S_FETCH: begin
                    // Data for slot k arrives in the cycle after its address.
                    r_sub <= r_sub + 3'd1;
                    case (r_sub)
                        3'd1: begin r_ch <= r_q_h; r_cvx <= r_q_vx; r_cvy <= r_q_vy; end
                        3'd2: r_d1 <= r_phase ? (VW+1)'($signed(r_q_vx))
                                              : (VW+1)'($signed(r_q_h));
                        3'd3: r_d1 <= r_d1 - (r_phase ? (VW+1)'($signed(r_q_vx))
                                                      : (VW+1)'($signed(r_q_h)));
                        3'd4: r_d2 <= r_phase ? (VW+1)'($signed(r_q_vy))
                                              : (VW+1)'($signed(r_q_h));
                        3'd5: r_d2 <= r_d2 - (r_phase ? (VW+1)'($signed(r_q_vy))
                                                      : (VW+1)'($signed(r_q_h)));
                        3'd6: r_acc <= (VW+2)'(r_d1) + (VW+2)'(r_d2);
                        default: ;
                    endcase
                end
                S_MUL: begin
                    if (r_phase)
                        r_prod <= (VW+GainW_C)'(r_acc * $signed({1'b0, r_height_gain}));
                    else
                        r_prod <= (VW+GainW_C)'((r_axis ? r_d2 : r_d1)
                                  * $signed({1'b0, r_vel_gain}));
                end
                S_UPD: begin
                    r_sat <= r_sat | upd_sat;
                    if (!r_phase) r_axis <= ~r_axis;
                end
                S_NEXT: begin
                    r_sub <= '0;
                    r_axis <= 1'b0;
                    if (r_col == swgs_pkg::LastCoord - 8'd1) begin
                        r_col <= 8'd1;
                        if (r_row == swgs_pkg::LastCoord - 8'd1) begin
                            r_row <= 8'd1; r_phase <= 1'b1;
                        end else r_row <= r_row + 8'd1;
                    end else r_col <= r_col + 8'd1;
                end
                S_OUT: if (!r_ovalid) begin
                    r_ovalid <= 1'b1;
                    r_out <= {1'b0, (r_cmd == swgs_pkg::CMD_STEP) & r_sat,
                              r_rd_vy, r_rd_vx, r_rd_h};
                    r_phase <= 1'b0;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== rtl/core/shallow_water_grid_step_checker.sv =====
// Port-level checker for shallow_water_grid_step, bound to the top level.
// Depends on the top level's ports only.
module shallow_water_grid_step_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // The block is busy right after it takes a command.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command taken back to back");
    // An accepted command is not followed by an immediate result.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result too early");
    // Padding bit stays zero.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[55])
        else $error("padding set");
endmodule

bind shallow_water_grid_step shallow_water_grid_step_checker u_chk (.*);

// ===== verif/testbench.sv =====
// Self-checking bench for shallow_water_grid_step: a directed table of
// commands, then random phases under several gain settings.
// Depends on swgs_pkg and the RTL top module.
module testbench;
    localparam int WatchdogLimit = 8000000;
    localparam int Cells = swgs_pkg::GridSide * swgs_pkg::GridSide;
    localparam int ValW = swgs_pkg::ValW;
    localparam int CoordW = swgs_pkg::CoordW;
    localparam int GainW = swgs_pkg::GainW;
    localparam int GridSide = swgs_pkg::GridSide;

    typedef struct packed {
        logic                   sat;
        logic signed [ValW-1:0] vy;
        logic signed [ValW-1:0] vx;
        logic signed [ValW-1:0] h;
    } t_result;

    typedef struct {
        swgs_pkg::t_cmd         cmd;
        logic [CoordW-1:0]      x;
        logic [CoordW-1:0]      y;
        logic signed [ValW-1:0] h;
        logic signed [ValW-1:0] vx;
        logic signed [ValW-1:0] vy;
        bit                     typed;
        t_result                res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    shallow_water_grid_step uut (.*);

    // Model of the grid, updated at each accepted transaction.
    logic signed [ValW-1:0] grid_h [Cells];
    logic signed [ValW-1:0] grid_vx [Cells];
    logic signed [ValW-1:0] grid_vy [Cells];
    logic [GainW-1:0] vel_gain_m;
    logic [GainW-1:0] height_gain_m;

    t_result pending_results[$];
    int errors = 0;
    int results_seen = 0;
    int steps_run = 0;
    int sat_steps = 0;
    int send_idle = 11;
    int recv_idle = 69;
    int quiet_cycles = 0;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    task automatic report(string what, logic [ValW-1:0] got, logic [ValW-1:0] want);
        errors++;
        if (errors <= 20)
            $display("mismatch on %s: got %h, want %h", what, got, want);
    endtask

    function automatic logic signed [ValW-1:0] clamp_update(int old, longint prod, ref bit sat);
        longint r;
        r = longint'(old) - ((prod + 2048) >>> swgs_pkg::FracBits);
        if (r > 131071) begin
            sat = 1'b1;
            return swgs_pkg::ValMax;
        end
        if (r < -131072) begin
            sat = 1'b1;
            return swgs_pkg::ValMin;
        end
        return r[ValW-1:0];
    endfunction

    function automatic bit advance_grid();
        bit sat;
        int c;
        longint d;
        sat = 1'b0;
        for (int y = 1; y < GridSide - 1; y++)
            for (int x = 1; x < GridSide - 1; x++) begin
                c = y * GridSide + x;
                d = longint'(grid_h[c+1]) - longint'(grid_h[c-1]);
                grid_vx[c] = clamp_update(int'(grid_vx[c]), d * longint'(vel_gain_m), sat);
                d = longint'(grid_h[c+GridSide]) - longint'(grid_h[c-GridSide]);
                grid_vy[c] = clamp_update(int'(grid_vy[c]), d * longint'(vel_gain_m), sat);
            end
        for (int y = 1; y < GridSide - 1; y++)
            for (int x = 1; x < GridSide - 1; x++) begin
                c = y * GridSide + x;
                d = (longint'(grid_vx[c+1]) - longint'(grid_vx[c-1]))
                  + (longint'(grid_vy[c+GridSide]) - longint'(grid_vy[c-GridSide]));
                grid_h[c] = clamp_update(int'(grid_h[c]), d * longint'(height_gain_m), sat);
            end
        return sat;
    endfunction

    function automatic t_result apply_command(t_row r);
        t_result res;
        int c;
        res = '0;
        c = int'(r.y) * GridSide + int'(r.x);
        case (r.cmd)
            swgs_pkg::CMD_WRITE: begin
                grid_h[c] = r.h;
                grid_vx[c] = r.vx;
                grid_vy[c] = r.vy;
            end
            swgs_pkg::CMD_STEP: begin
                res.sat = advance_grid();
                steps_run++;
                if (res.sat) sat_steps++;
            end
            swgs_pkg::CMD_READ: begin
                res.h = grid_h[c];
                res.vx = grid_vx[c];
                res.vy = grid_vy[c];
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_command(t_row r);
        t_result res;
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {r.vy, r.vx, r.h, r.y, r.x, r.cmd};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        res = apply_command(r);
        pending_results.push_back(r.typed ? r.res : res);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_gain(logic index, logic [GainW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        if (index == swgs_pkg::CFG_VEL_GAIN) vel_gain_m = value;
        else height_gain_m = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CoordW-1:0] pick_coord();
        int u;
        u = $urandom_range(99);
        if (u < 75) return CoordW'($urandom_range(5));
        if (u < 90) return swgs_pkg::LastCoord - CoordW'($urandom_range(1));
        return CoordW'($urandom);
    endfunction

    function automatic logic signed [ValW-1:0] pick_value();
        if ($urandom_range(1)) return ValW'($urandom);
        return ValW'($urandom_range(8192)) - ValW'(4096);
    endfunction

    function automatic t_row random_row(swgs_pkg::t_cmd cmd);
        t_row r;
        r.cmd = cmd;
        r.x = pick_coord();
        r.y = pick_coord();
        r.h = pick_value();
        r.vx = pick_value();
        r.vy = pick_value();
        r.typed = 1'b0;
        r.res = '0;
        return r;
    endfunction

    // Receiver side and checker.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[54:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                report("unexpected result", got.h, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.h !== want.h) report("height_out", got.h, want.h);
                if (got.vx !== want.vx) report("vel_x_out", got.vx, want.vx);
                if (got.vy !== want.vy) report("vel_y_out", got.vy, want.vy);
                if (got.sat !== want.sat)
                    report("saturated", ValW'(got.sat), ValW'(want.sat));
            end
            if (m_axis_tdata[55] !== 1'b0)
                report("pad bit", ValW'(m_axis_tdata[55]), '0);
        end
        m_axis_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end

    // Any transaction restarts the count; a step keeps the input busy through
    // both of its grid passes.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog expired with %0d results outstanding",
                     pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    t_row directed[$];

    function automatic t_row mk(swgs_pkg::t_cmd cmd, int x, int y, int h, int vx, int vy,
                                bit typed, int eh, int evx, int evy);
        t_row r;
        r.cmd = cmd;
        r.x = CoordW'(x);
        r.y = CoordW'(y);
        r.h = ValW'(h);
        r.vx = ValW'(vx);
        r.vy = ValW'(vy);
        r.typed = typed;
        r.res.h = ValW'(eh);
        r.res.vx = ValW'(evx);
        r.res.vy = ValW'(evy);
        r.res.sat = 1'b0;
        return r;
    endfunction

    initial begin
        t_row r;
        int n;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= swgs_pkg::CFG_VEL_GAIN;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;
        for (int i = 0; i < Cells; i++) begin
            grid_h[i] = swgs_pkg::HeightReset;
            grid_vx[i] = '0;
            grid_vy[i] = '0;
        end
        vel_gain_m = swgs_pkg::VelGainReset;
        height_gain_m = swgs_pkg::HeightGainReset;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(mk(swgs_pkg::CMD_READ, 0, 0, 0, 0, 0, 1, 4096, 0, 0));
        directed.push_back(mk(swgs_pkg::CMD_READ, 255, 255, -1, -1, -1, 1, 4096, 0, 0));
        directed.push_back(mk(swgs_pkg::CMD_WRITE, 0, 0, 131071, -131072, -1, 1, 0, 0, 0));
        directed.push_back(mk(swgs_pkg::CMD_READ, 0, 0, 0, 0, 0, 1, 131071, -131072, -1));
        directed.push_back(mk(swgs_pkg::CMD_WRITE, 255, 0, -131072, 131071, 0, 1, 0, 0, 0));
        directed.push_back(mk(swgs_pkg::CMD_READ, 255, 0, 0, 0, 0, 1, -131072, 131071, 0));
        directed.push_back(mk(swgs_pkg::CMD_NONE, 255, 255, -1, -1, -1, 1, 0, 0, 0));
        directed.push_back(mk(swgs_pkg::CMD_WRITE, 10, 10, 131071, 0, 0, 1, 0, 0, 0));
        directed.push_back(mk(swgs_pkg::CMD_WRITE, 12, 10, -131072, 0, 0, 1, 0, 0, 0));
        directed.push_back(mk(swgs_pkg::CMD_WRITE, 11, 12, 0, 131071, -131072, 1, 0, 0, 0));
        directed.push_back(mk(swgs_pkg::CMD_WRITE, 0, 128, 131071, 131071, 131071,
                              1, 0, 0, 0));
        directed.push_back(mk(swgs_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(swgs_pkg::CMD_READ, 11, 10, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(swgs_pkg::CMD_READ, 10, 10, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(swgs_pkg::CMD_READ, 11, 11, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(swgs_pkg::CMD_READ, 12, 11, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(swgs_pkg::CMD_READ, 1, 128, 0, 0, 0, 0, 0, 0, 0));
        // Edge cells keep their values across a step.
        directed.push_back(mk(swgs_pkg::CMD_READ, 0, 0, 0, 0, 0, 1, 131071, -131072, -1));
        directed.push_back(mk(swgs_pkg::CMD_READ, 0, 128, 0, 0, 0, 1, 131071, 131071, 131071));
        foreach (directed[i]) send_command(directed[i]);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 11 : (phase == 1) ? 69 : 0;
            recv_idle = (phase == 0) ? 69 : (phase == 1) ? 11 : 0;
            case (phase)
                0: begin
                    write_gain(swgs_pkg::CFG_VEL_GAIN, 16'hFFFF);
                    write_gain(swgs_pkg::CFG_HEIGHT_GAIN, 16'hFFFF);
                end
                1: begin
                    write_gain(swgs_pkg::CFG_VEL_GAIN, 16'h0000);
                    write_gain(swgs_pkg::CFG_HEIGHT_GAIN, 16'h0000);
                end
                default: begin
                    write_gain(swgs_pkg::CFG_VEL_GAIN, GainW'($urandom));
                    write_gain(swgs_pkg::CFG_HEIGHT_GAIN, GainW'($urandom_range(1023)));
                end
            endcase
            // Seed the window, step once, then read it back among fresh writes.
            for (n = 0; n < 12; n++) send_command(random_row(swgs_pkg::CMD_WRITE));
            send_command(random_row(swgs_pkg::CMD_STEP));
            for (n = 0; n < 20; n++) begin
                case ($urandom_range(9))
                    0: r = random_row(swgs_pkg::CMD_NONE);
                    1, 2: r = random_row(swgs_pkg::CMD_WRITE);
                    default: r = random_row(swgs_pkg::CMD_READ);
                endcase
                send_command(r);
            end
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        $display("covered %0d results, %0d grid steps (%0d saturating), gains at extremes",
                 results_seen, steps_run, sat_steps);
        if (errors == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
